@@ rtl/dirty_rect_coalescer_defines.svh @@
// ----------------------------------------------------------------------------
// dirty rectangle coalescer assertion macros
// shared property forms used by the top-level checks
// ----------------------------------------------------------------------------
`ifndef DIRTY_RECT_COALESCER_DEFINES_SVH
`define DIRTY_RECT_COALESCER_DEFINES_SVH

// a condition implies another in the same cycle
`define DRC_ASSERT_IMPLY(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a condition implies another in the next cycle
`define DRC_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

@@ rtl/drc_pkg.sv @@
// ----------------------------------------------------------------------------
// drc_pkg
// shared types and constants of the dirty rectangle coalescer
// ----------------------------------------------------------------------------
package drc_pkg;
  localparam int MAX_RECTS  = 16;
  localparam int COORD_BITS = 12;
  localparam int SIZE_BITS  = COORD_BITS + 1;
  localparam int BOX_BITS   = SIZE_BITS + 1;
  localparam int CNT_BITS   = $clog2(MAX_RECTS + 1);
  localparam int IDX_BITS   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int AREA_BITS  = 2 * SIZE_BITS;
  localparam int COST_BITS  = 2 * BOX_BITS + 1;
  localparam int TOT_BITS   = AREA_BITS + CNT_BITS;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_INVAL = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]  w;
    logic [SIZE_BITS-1:0]  h;
  } rect_t;

  // ring control from the sequencer to every cell
  typedef struct packed {
    logic shift;   // rotate the ring by one cell
    logic load;    // tail cell takes the inserted value in place of the head
  } ring_ctl_t;
endpackage

@@ rtl/drc_cell.sv @@
// ----------------------------------------------------------------------------
// drc_cell
// one table entry of the rotating rectangle ring
// ----------------------------------------------------------------------------
module drc_cell (
  input  logic              clk,
  input  drc_pkg::ring_ctl_t ctl,
  input  logic              is_tail,
  input  drc_pkg::rect_t    ins,
  input  drc_pkg::rect_t    prev,
  output drc_pkg::rect_t    cur
);
  import drc_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      cur <= (is_tail && ctl.load) ? ins : prev;
    end
  end
endmodule

@@ rtl/drc_cost.sv @@
// ----------------------------------------------------------------------------
// drc_cost
// merge cost and bounding box of the head cell against the new area
// ----------------------------------------------------------------------------
module drc_cost (
  input  logic                          clk,
  input  drc_pkg::rect_t                stored,
  input  drc_pkg::rect_t                area,
  output drc_pkg::rect_t                bbox,
  output logic signed [drc_pkg::COST_BITS-1:0] cost
);
  import drc_pkg::*;

  // right and bottom edges may pass the 13-bit size range
  logic [BOX_BITS-1:0] sx2, sy2, ax2, ay2, x2, y2;
  logic [COORD_BITS-1:0] x1, y1;
  logic [BOX_BITS-1:0] bw, bh;
  logic [2*BOX_BITS-1:0] pb;
  logic [AREA_BITS-1:0] ps, pa;

  always_comb begin
    sx2 = BOX_BITS'(stored.x) + BOX_BITS'(stored.w);
    sy2 = BOX_BITS'(stored.y) + BOX_BITS'(stored.h);
    ax2 = BOX_BITS'(area.x) + BOX_BITS'(area.w);
    ay2 = BOX_BITS'(area.y) + BOX_BITS'(area.h);
    x1 = (stored.x < area.x) ? stored.x : area.x;
    y1 = (stored.y < area.y) ? stored.y : area.y;
    x2 = (sx2 > ax2) ? sx2 : ax2;
    y2 = (sy2 > ay2) ? sy2 : ay2;
    bw = x2 - BOX_BITS'(x1);
    bh = y2 - BOX_BITS'(y1);
  end

  // products registered before the subtraction
  always_ff @(posedge clk) begin
    pb <= bw * bh;
    ps <= stored.w * stored.h;
    pa <= area.w * area.h;
    bbox <= '{x: x1, y: y1, w: bw[SIZE_BITS-1:0], h: bh[SIZE_BITS-1:0]};
  end

  assign cost = $signed({1'b0, pb}) - $signed({3'b000, ps}) - $signed({3'b000, pa});
endmodule

@@ rtl/dirty_rect_coalescer.sv @@
// ----------------------------------------------------------------------------
// dirty_rect_coalescer
// collects dirty screen areas into a rectangle table and emits them on flush
// ----------------------------------------------------------------------------
// The table lives in a ring of MAX_RECTS cells that rotates one place per
// cycle while it is shifted; the merge cost is evaluated on the head cell
// only. An add request takes one turn to score every stored rectangle
// through a one-stage multiplier, then a second turn in which the tail
// cell takes the merged box or the appended area as the target entry
// passes the head. A flush sums the areas over one turn, decides in S_DEC
// and then loads one result per entry as the output frees, or a single
// full-screen or empty result. Invalidate and an unknown command are
// handled in S_IDLE. One request is worked at a time; the result register
// frees the input as soon as the last result is loaded.
`include "dirty_rect_coalescer_defines.svh"
module dirty_rect_coalescer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0], area_x[13:2], area_y[25:14], area_w[38:26], area_h[51:39]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rect_x[11:0], rect_y[23:12], rect_w[36:24], rect_h[49:37]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // empty_res[0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import drc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCORE = 7'b0000010,  // turn one: cost per entry
    S_SEEK  = 7'b0000100,  // turn two: replace or append at the tail
    S_SUM   = 7'b0001000,  // flush: sum areas
    S_DEC   = 7'b0010000,
    S_EMIT  = 7'b0100000,  // send entries from the head
    S_ONE   = 7'b1000000   // single full or empty result
  } state_t;

  state_t state;

  // configuration registers
  logic [4:0]  max_rects;
  logic [12:0] screen_width, screen_height;
  logic        full_only;
  logic        wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rects <= 5'd16;
      screen_width <= 13'd320;
      screen_height <= 13'd240;
      full_only <= 1'b0;
    end else if (wr) begin
      unique case (paddr[3:2])
        2'd0: max_rects <= pwdata[4:0];
        2'd1: screen_width <= pwdata[12:0];
        2'd2: screen_height <= pwdata[12:0];
        default: full_only <= pwdata[0];
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      2'd0: prdata = {27'd0, max_rects};
      2'd1: prdata = {19'd0, screen_width};
      2'd2: prdata = {19'd0, screen_height};
      default: prdata = {31'd0, full_only};
    endcase
  end

  // effective table limit
  logic [CNT_BITS-1:0] lim;
  always_comb begin
    if (max_rects == 5'd0) lim = CNT_BITS'(1);
    else if (32'(max_rects) > MAX_RECTS) lim = CNT_BITS'(MAX_RECTS);
    else lim = CNT_BITS'(max_rects);
  end

  // ring of cells; ring[0] is the head, the last cell takes the head value
  rect_t     ring [MAX_RECTS];
  rect_t     ins;
  ring_ctl_t ctl;
  for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cell
    drc_cell u_cell (
      .clk(clk), .ctl(ctl), .is_tail(g == MAX_RECTS - 1), .ins(ins),
      .prev(ring[(g + 1) % MAX_RECTS]), .cur(ring[g])
    );
  end

  rect_t area;
  rect_t bbox;
  rect_t best_box;
  logic signed [COST_BITS-1:0] cost, best_cost;
  drc_cost u_cost (.clk(clk), .stored(ring[0]), .area(area), .bbox(bbox), .cost(cost));

  logic [CNT_BITS-1:0] count, step, best, target;
  logic                full_pending, found, score_vld, one_empty;
  logic [TOT_BITS-1:0] total;
  logic [AREA_BITS-1:0] head_area;
  logic                merge;

  // output register
  logic        out_vld;
  rect_t       out_r, out_r_next;
  logic        out_last, out_empty;
  logic        out_last_next, out_empty_next;
  logic        out_free, out_load;
  assign out_free = !out_vld || m_axis_tready;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata = {6'd0, out_r.h, out_r.w, out_r.y, out_r.x};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_empty;

  assign s_axis_tready = (state == S_IDLE);
  assign head_area = ring[0].w * ring[0].h;
  assign merge = found && (best_cost <= 0 || count >= lim);
  // entry rewritten in turn two: the best one on a merge, else the next free
  assign target = merge ? best : count;

  // ring rotation; in S_SEEK the target entry is replaced as it leaves the head
  always_comb begin
    ctl = '0;
    ins = merge ? best_box : area;
    unique case (state)
      S_SCORE: ctl.shift = (step < CNT_BITS'(MAX_RECTS));
      S_SEEK: begin
        ctl.shift = 1'b1;
        ctl.load = (step == target) && (merge || count < CNT_BITS'(MAX_RECTS));
      end
      S_SUM:  ctl.shift = (step < CNT_BITS'(MAX_RECTS));
      S_EMIT: ctl.shift = out_free;
      default: ;
    endcase
  end

  // next result
  always_comb begin
    out_load = 1'b0;
    out_r_next = ring[0];
    out_last_next = 1'b0;
    out_empty_next = 1'b0;
    unique case (state)
      S_ONE: begin
        out_load = out_free;
        out_last_next = 1'b1;
        out_empty_next = one_empty;
        out_r_next = '0;
        if (!one_empty) begin
          out_r_next.w = screen_width;
          out_r_next.h = screen_height;
        end
      end
      S_EMIT: begin
        out_load = out_free;
        out_last_next = (step + CNT_BITS'(1) == count);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= out_load || (out_vld && !m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_r_next;
      out_last <= out_last_next;
      out_empty <= out_empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      full_pending <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            area <= '{x: s_axis_tdata[13:2], y: s_axis_tdata[25:14],
                      w: s_axis_tdata[38:26], h: s_axis_tdata[51:39]};
            step <= '0;
            found <= 1'b0;
            score_vld <= 1'b0;
            total <= '0;
            unique case (s_axis_tdata[1:0])
              CMD_ADD:   state <= S_SCORE;
              CMD_FLUSH: state <= S_SUM;
              CMD_INVAL: full_pending <= 1'b1;
              default: ;
            endcase
          end
        end
        S_SCORE: begin
          // cost of ring entry step-1 appears in the cycle after it was head
          score_vld <= (step < count);
          if (score_vld && (!found || cost < best_cost)) begin
            found <= 1'b1;
            best_cost <= cost;
            best <= step - CNT_BITS'(1);
            best_box <= bbox;
          end
          if (step == CNT_BITS'(MAX_RECTS)) begin
            step <= '0;
            state <= S_SEEK;
          end else begin
            step <= step + CNT_BITS'(1);
          end
        end
        S_SEEK: begin
          if (step == CNT_BITS'(MAX_RECTS - 1)) begin
            if (!merge && count < CNT_BITS'(MAX_RECTS)) count <= count + CNT_BITS'(1);
            state <= S_IDLE;
          end
          step <= step + CNT_BITS'(1);
        end
        S_SUM: begin
          if (step == CNT_BITS'(MAX_RECTS)) begin
            state <= S_DEC;
          end else begin
            if (step < count) total <= total + TOT_BITS'(head_area);
            step <= step + CNT_BITS'(1);
          end
        end
        S_DEC: begin
          step <= '0;
          if (full_pending || full_only ||
              total >= TOT_BITS'(screen_width) * TOT_BITS'(screen_height)) begin
            full_pending <= 1'b0;
            one_empty <= 1'b0;
            state <= S_ONE;
          end else if (count == '0) begin
            one_empty <= 1'b1;
            state <= S_ONE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_ONE: begin
          if (out_free) begin
            count <= '0;
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (step + CNT_BITS'(1) == count) begin
              count <= '0;
              state <= S_IDLE;
            end
            step <= step + CNT_BITS'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DRC_ASSERT_IMPLY(a_busy_no_ready, state != S_IDLE, !s_axis_tready, "ready while busy")
  `DRC_ASSERT_IMPLY(a_count_max, 1'b1, count <= CNT_BITS'(MAX_RECTS), "count overflow")
  `DRC_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
endmodule

@@ tb/dirty_rect_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dirty_rect_checker
// watches the request, result and register ports of the coalescer, predicts
// every rectangle that a flush sends and compares each result field by field
// ----------------------------------------------------------------------------
module dirty_rect_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          error_count,
  output int          rects_pending
);
  import drc_pkg::*;

  localparam logic [3:0] REG_MAX_RECTS = 4'h0;
  localparam logic [3:0] REG_SCREEN_W  = 4'h4;
  localparam logic [3:0] REG_SCREEN_H  = 4'h8;
  localparam logic [3:0] REG_FULL_ONLY = 4'hC;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]  w;
    logic [SIZE_BITS-1:0]  h;
    logic                  last;
    logic                  empty;
  } sent_rect_t;

  logic [4:0]           limit_reg;
  logic [SIZE_BITS-1:0] scr_w;
  logic [SIZE_BITS-1:0] scr_h;
  logic                 full_only_q;
  rect_t                rect_table [MAX_RECTS];
  int unsigned          entries;
  bit                   full_due;
  sent_rect_t           pending_rects [$];

  function automatic int unsigned umin(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic int unsigned umax(int unsigned a, int unsigned b);
    return (a > b) ? a : b;
  endfunction

  // merge into the cheapest entry or append
  task automatic coalesce_area(rect_t a);
    int unsigned limit, best, x1, y1, x2, y2;
    longint cost, best_cost;
    bit found;
    limit = limit_reg;
    if (limit < 1) limit = 1;
    if (limit > MAX_RECTS) limit = MAX_RECTS;
    found = 0;
    best = 0;
    best_cost = 0;
    for (int i = 0; i < entries; i++) begin
      x1 = umin(rect_table[i].x, a.x);
      y1 = umin(rect_table[i].y, a.y);
      x2 = umax(rect_table[i].x + rect_table[i].w, a.x + a.w);
      y2 = umax(rect_table[i].y + rect_table[i].h, a.y + a.h);
      cost = longint'(x2 - x1) * longint'(y2 - y1)
           - longint'(rect_table[i].w) * longint'(rect_table[i].h)
           - longint'(a.w) * longint'(a.h);
      if (!found || cost < best_cost) begin
        found = 1;
        best = i;
        best_cost = cost;
      end
    end
    if (found && (best_cost <= 0 || entries >= limit)) begin
      x1 = umin(rect_table[best].x, a.x);
      y1 = umin(rect_table[best].y, a.y);
      x2 = umax(rect_table[best].x + rect_table[best].w, a.x + a.w);
      y2 = umax(rect_table[best].y + rect_table[best].h, a.y + a.h);
      rect_table[best].x = COORD_BITS'(x1);
      rect_table[best].y = COORD_BITS'(y1);
      rect_table[best].w = SIZE_BITS'(x2 - x1);
      rect_table[best].h = SIZE_BITS'(y2 - y1);
    end else if (entries < MAX_RECTS) begin
      rect_table[entries] = a;
      entries++;
    end
  endtask

  // queue the rectangles that a flush sends
  task automatic flush_table();
    longint unsigned total;
    sent_rect_t r;
    total = 0;
    for (int i = 0; i < entries; i++)
      total += longint'(rect_table[i].w) * longint'(rect_table[i].h);
    if (full_due || full_only_q || total >= longint'(scr_w) * longint'(scr_h)) begin
      full_due = 0;
      r = '{x: '0, y: '0, w: scr_w, h: scr_h, last: 1'b1, empty: 1'b0};
      pending_rects.push_back(r);
    end else if (entries == 0) begin
      r = '{x: '0, y: '0, w: '0, h: '0, last: 1'b1, empty: 1'b1};
      pending_rects.push_back(r);
    end else begin
      for (int i = 0; i < entries; i++) begin
        r = '{x: rect_table[i].x, y: rect_table[i].y, w: rect_table[i].w,
              h: rect_table[i].h, last: (i == entries - 1), empty: 1'b0};
        pending_rects.push_back(r);
      end
    end
    entries = 0;
  endtask

  task automatic report_mismatch(string what, sent_rect_t e, sent_rect_t a);
    error_count++;
    if (error_count <= 10)
      $display("%0t %s: expected x=%0d y=%0d w=%0d h=%0d last=%0b empty=%0b,",
               $realtime, what, e.x, e.y, e.w, e.h, e.last, e.empty,
               " got x=%0d y=%0d w=%0d h=%0d last=%0b empty=%0b",
               a.x, a.y, a.w, a.h, a.last, a.empty);
  endtask

  always @(posedge clk) begin
    sent_rect_t got, want;
    rect_t area;
    if (rst) begin
      limit_reg   = 5'd16;
      scr_w       = 13'd320;
      scr_h       = 13'd240;
      full_only_q = 1'b0;
      entries     = 0;
      full_due    = 1;
      error_count = 0;
      pending_rects.delete();
    end else begin
      // results first: they belong to requests taken at earlier edges
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{x: m_axis_tdata[11:0], y: m_axis_tdata[23:12],
                w: m_axis_tdata[36:24], h: m_axis_tdata[49:37],
                last: m_axis_tlast, empty: m_axis_tuser};
        if (pending_rects.size() == 0) begin
          want = '{x: 'x, y: 'x, w: 'x, h: 'x, last: 'x, empty: 'x};
          report_mismatch("unexpected result", want, got);
        end else begin
          want = pending_rects.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
              got.h !== want.h || got.last !== want.last || got.empty !== want.empty)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        area = '{x: s_axis_tdata[13:2], y: s_axis_tdata[25:14],
                 w: s_axis_tdata[38:26], h: s_axis_tdata[51:39]};
        case (s_axis_tdata[1:0])
          CMD_ADD:   coalesce_area(area);
          CMD_FLUSH: flush_table();
          CMD_INVAL: full_due = 1;
          default: ;
        endcase
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_MAX_RECTS: limit_reg   = pwdata[4:0];
          REG_SCREEN_W:  scr_w       = pwdata[12:0];
          REG_SCREEN_H:  scr_h       = pwdata[12:0];
          REG_FULL_ONLY: full_only_q = pwdata[0];
          default: ;
        endcase
      end
    end
    rects_pending = pending_rects.size();
  end
endmodule

@@ tb/dirty_rect_coalescer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dirty_rect_coalescer_tb
// drives add, flush and invalidate requests with bursty timing and a
// stalling result side over a series of register settings; the checker
// beside the block predicts and compares every emitted rectangle
// ----------------------------------------------------------------------------
module dirty_rect_coalescer_tb;
  import drc_pkg::*;

  // register byte addresses
  localparam logic [3:0] REG_MAX_RECTS = 4'h0;
  localparam logic [3:0] REG_SCREEN_W  = 4'h4;
  localparam logic [3:0] REG_SCREEN_H  = 4'h8;
  localparam logic [3:0] REG_FULL_ONLY = 4'hC;
  // command code the block must ignore
  localparam logic [1:0] CMD_NONE = 2'd3;
  // cycles an add may still run after the last result has been seen
  localparam int SETTLE_CYCLES = 80;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // cmd[1:0], area_x[13:2], area_y[25:14], area_w[38:26], area_h[51:39]
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // rect_x[11:0], rect_y[23:12], rect_w[36:24], rect_h[49:37]
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  // empty_res[0]
  logic        m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int error_count;
  int rects_pending;

  // sender burst state
  int burst_left = 0;
  // current screen, used to keep most areas on screen
  int cur_w = 320;
  int cur_h = 240;
  int cur_limit = 16;

  // receiver stall pattern
  int rx_tick = 0;
  int rx_mode = 0;

  dirty_rect_coalescer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  dirty_rect_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .error_count   (error_count),
    .rects_pending (rects_pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // receiver: switches between always ready, coin flips and long stalls
  initial m_axis_tready = 1'b0;
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= (rx_tick % 11) < 2;
    endcase
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // one request, held until taken; gaps only open between bursts
  task automatic send_req(logic [1:0] cmd, logic [11:0] x, logic [11:0] y,
                          logic [12:0] w, logic [12:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, h, w, y, x, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  // drop valid and let every result drain and any add finish
  task automatic go_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (rects_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int lim, int sw, int sh, bit fo);
    go_quiet();
    reg_write(REG_MAX_RECTS, lim);
    reg_write(REG_SCREEN_W, sw);
    reg_write(REG_SCREEN_H, sh);
    reg_write(REG_FULL_ONLY, fo);
    cur_w = (sw < 1) ? 1 : ((sw > 4096) ? 4096 : sw);
    cur_h = (sh < 1) ? 1 : ((sh > 4096) ? 4096 : sh);
    cur_limit = lim;
  endtask

  // mostly small areas on screen so merges and appends both happen,
  // sometimes anything the fields allow
  task automatic send_area();
    int x, y, w, h;
    if ($urandom_range(0, 7) == 0) begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
      w = $urandom_range(0, 4096);
      h = $urandom_range(0, 4096);
    end else begin
      x = $urandom_range(0, cur_w - 1);
      y = $urandom_range(0, cur_h - 1);
      w = $urandom_range(0, (cur_w + 3) / 4);
      h = $urandom_range(0, (cur_h + 3) / 4);
    end
    send_req(CMD_ADD, 12'(x), 12'(y), 13'(w), 13'(h));
  endtask

  // add sequences closed by a flush, with invalidates and junk mixed in
  task automatic run_traffic(int n_items);
    int sent, adds;
    sent = 0;
    while (sent < n_items) begin
      adds = $urandom_range(0, cur_limit + 4);
      if (adds > 20) adds = 20;
      for (int i = 0; i < adds; i++) begin
        case ($urandom_range(0, 19))
          0: send_req(CMD_INVAL, 12'($urandom), 12'($urandom), 13'($urandom), 13'($urandom));
          1: send_req(CMD_NONE, 12'($urandom), 12'($urandom), 13'($urandom), 13'($urandom));
          default: send_area();
        endcase
        sent++;
      end
      send_req(CMD_FLUSH, 12'($urandom), 12'($urandom), 13'($urandom), 13'($urandom));
      sent++;
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: first flush is full, then empty, extremes, merge, junk
    send_req(CMD_FLUSH, 0, 0, 0, 0);
    send_req(CMD_FLUSH, 12'hFFF, 12'hFFF, 13'h1FFF, 13'h1FFF);
    send_req(CMD_ADD, 0, 0, 0, 0);
    send_req(CMD_ADD, 12'd4095, 12'd4095, 13'd4096, 13'd4096);
    send_req(CMD_FLUSH, 0, 0, 0, 0);
    send_req(CMD_ADD, 10, 10, 5, 5);
    send_req(CMD_ADD, 12, 12, 5, 5);
    send_req(CMD_ADD, 200, 100, 8, 8);
    send_req(CMD_NONE, 12'hFFF, 12'hFFF, 13'h1FFF, 13'h1FFF);
    send_req(CMD_ADD, 0, 0, 13'd4096, 0);
    send_req(CMD_ADD, 300, 200, 0, 13'd4096);
    send_req(CMD_FLUSH, 0, 0, 0, 0);
    send_req(CMD_ADD, 1, 1, 2, 2);
    send_req(CMD_INVAL, 0, 0, 0, 0);
    send_req(CMD_FLUSH, 0, 0, 0, 0);
    send_req(CMD_ADD, 0, 0, 320, 240);
    send_req(CMD_FLUSH, 0, 0, 0, 0);

    // table of one, limit clamped from zero, big screen
    set_config(1, 64, 48, 0);
    run_traffic(35);
    set_config(0, 4096, 4096, 0);
    run_traffic(35);
    set_config(4, 4096, 4096, 0);
    run_traffic(40);
    set_config(31, 8191, 8191, 0);
    run_traffic(40);
    // zero screen size: every flush answers full
    set_config(8, 0, 0, 0);
    run_traffic(25);
    set_config(16, 320, 240, 1);
    run_traffic(25);
    set_config(16, 1, 1, 0);
    run_traffic(25);
    set_config(16, 320, 240, 0);
    run_traffic(50);
    // lower the limit under the current fill: adds must merge until the next flush
    send_req(CMD_FLUSH, 0, 0, 0, 0);
    for (int i = 0; i < 10; i++)
      send_req(CMD_ADD, 12'(30 * i), 12'(20 * i), 3, 3);
    set_config(2, 320, 240, 0);
    run_traffic(30);

    go_quiet();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
